@@ rtl/srbw_pkg.sv @@
package srbw_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_WINDOW = 2'd2,
    KIND_RESET  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_ACK       = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 7;

  // Output queue depth: one word showing, one arriving from the RAM, one spare.
  localparam int FIFO_DEPTH = 3;

  typedef struct packed {
    status_t               status;
    logic [SAMPLE_W-1:0]   sample;
    logic                  last;
    logic [LEVEL_W-1:0]    fill_level;
    logic                  window_ready;
  } result_t;

endpackage

@@ rtl/sample_ring_buffer_window_read.sv @@
// Circular store of signed 16-bit samples that overwrites the oldest entry
// when full. Items arrive on the in_ channel: in_tuser selects write, strict
// frame read, lenient window read or pointer reset. Results leave on the out_
// channel, one word each, with out_tlast on the final word of an item.
// Registers capacity and window_threshold are written through cfg_; the user
// must write them only while idle, as the block itself does not enforce it.
// A write is stored at the edge that takes it, and its acknowledge word is
// queued at that edge; writes are taken one per cycle while the output queue
// has room. A read is set up at the edge that takes it, then issues one RAM
// read per cycle while its word has a queue slot; the registered RAM read
// queues each word in the cycle after its issue. Not-ready and empty answers
// are queued at the edge that takes the item. A pointer reset gives no word.
// Reset clears the pointer, the fill count, the output queue and sets both
// registers to 64; sample memory contents are left as they are.
// When the receiver stalls, up to three words wait in the output queue and
// RAM reads pause; in_tready falls once the queue is full.
module sample_ring_buffer_window_read
  import srbw_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sample_in[15:0], length[22:16], zero[23]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // sample_out[15:0], fill_level[22:16], window_ready[23]
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [LEVEL_W-1:0] DEPTH_L = LEVEL_W'(DEPTH);

  state_t              state_r, state_nxt;
  logic [LEVEL_W-1:0]  cap_cfg_r;
  logic [LEVEL_W-1:0]  thr_r;
  logic [PW-1:0]       wp_r, wp_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [PW-1:0]       addr_r, addr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                rd_last_r, rd_last_nxt;

  logic [CW-1:0]       cap_e;
  logic [CW-1:0]       fill_e;
  logic [PW-1:0]       wp_e;
  logic [CW-1:0]       wp_inc;
  logic [CW:0]         fill_inc;
  logic [CW-1:0]       wr_fill;
  logic [LEVEL_W-1:0]  len;
  logic [LEVEL_W-1:0]  fill_l;
  logic [LEVEL_W-1:0]  n_l;
  logic [CW-1:0]       n;
  logic [CW:0]         start_sum;
  logic [CW:0]         start_red;
  logic [CW-1:0]       addr_inc;
  logic                win_rdy;
  logic                accept;
  logic                issue;
  logic                push_stat;
  result_t             stat_res;
  logic                ram_we;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic                fifo_push;
  result_t             fifo_in;
  result_t             fifo_head;
  logic                fifo_valid;
  logic [1:0]          fifo_count;

  // Effective capacity, fill and pointer after any change of capacity.
  always_comb begin
    if (cap_cfg_r == '0) begin
      cap_e = CW'(1);
    end else if (cap_cfg_r > DEPTH_L) begin
      cap_e = CW'(DEPTH);
    end else begin
      cap_e = cap_cfg_r[CW-1:0];
    end
  end

  assign fill_e   = (fill_r > cap_e) ? cap_e : fill_r;
  assign wp_e     = (CW'(wp_r) >= cap_e) ? '0 : wp_r;
  assign wp_inc   = CW'(wp_e) + CW'(1);
  assign fill_inc = {1'b0, fill_e} + (CW + 1)'(1);
  assign wr_fill  = (fill_inc > {1'b0, cap_e}) ? cap_e : fill_inc[CW-1:0];
  assign fill_l   = LEVEL_W'(fill_e);
  assign win_rdy  = (fill_l >= thr_r);

  assign len       = in_tdata[22:16];
  assign n_l       = (fill_l < len) ? fill_l : len;
  assign n         = n_l[CW-1:0];
  // Oldest requested entry: (wp + cap - n) mod cap, the sum stays below 2 * cap.
  assign start_sum = {1'b0, CW'(wp_e)} + {1'b0, cap_e} - {1'b0, n};
  assign start_red = (start_sum >= {1'b0, cap_e}) ? start_sum - {1'b0, cap_e} : start_sum;
  assign addr_inc  = CW'(addr_r) + CW'(1);

  assign in_tready = (state_r == S_IDLE) && !rd_vld_r && (fifo_count != 2'(FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;
  // A read is issued only when its word has a queue slot waiting for it.
  assign issue     = (state_r == S_READ) &&
                     ((3'(fifo_count) + 3'(rd_vld_r)) < 3'(FIFO_DEPTH));

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    addr_nxt    = addr_r;
    cnt_nxt     = cnt_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = rd_last_r;
    ram_we      = 1'b0;
    push_stat   = 1'b0;
    stat_res    = '{status: ST_ACK, sample: '0, last: 1'b1,
                    fill_level: fill_l, window_ready: win_rdy};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(in_tuser))
            KIND_WRITE: begin
              ram_we                = 1'b1;
              wp_nxt                = (wp_inc >= cap_e) ? '0 : wp_inc[PW-1:0];
              fill_nxt              = wr_fill;
              push_stat             = 1'b1;
              stat_res.fill_level   = LEVEL_W'(wr_fill);
              stat_res.window_ready = (LEVEL_W'(wr_fill) >= thr_r);
            end
            KIND_FRAME: begin
              if (len == '0 || fill_l < len) begin
                push_stat       = 1'b1;
                stat_res.status = ST_NOT_READY;
              end else begin
                state_nxt = S_READ;
                addr_nxt  = start_red[PW-1:0];
                cnt_nxt   = n;
              end
            end
            KIND_WINDOW: begin
              if (n_l == '0) begin
                push_stat       = 1'b1;
                stat_res.status = ST_EMPTY;
              end else begin
                state_nxt = S_READ;
                addr_nxt  = start_red[PW-1:0];
                cnt_nxt   = n;
              end
            end
            KIND_RESET: begin
              wp_nxt   = '0;
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (issue) begin
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (cnt_r == CW'(1));
          addr_nxt    = (addr_inc >= cap_e) ? '0 : addr_inc[PW-1:0];
          cnt_nxt     = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      fill_r    <= '0;
      rd_vld_r  <= 1'b0;
      cap_cfg_r <= LEVEL_W'(64);
      thr_r     <= LEVEL_W'(64);
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cfg_we && cfg_addr == REG_CAPACITY) begin
        cap_cfg_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == REG_THRESHOLD) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    cnt_r     <= cnt_nxt;
    rd_last_r <= rd_last_nxt;
  end

  // Reads happen only in the read state and writes only on an accepted write,
  // so a read never meets a write to the same entry in flight.
  srbw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_e),
    .wdata (in_tdata[15:0]),
    .re    (issue),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign fifo_push = push_stat || rd_vld_r;

  always_comb begin
    if (rd_vld_r) begin
      fifo_in = '{status: ST_DATA, sample: ram_rdata, last: rd_last_r,
                  fill_level: fill_l, window_ready: win_rdy};
    end else begin
      fifo_in = stat_res;
    end
  end

  srbw_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (fifo_in),
    .pop       (out_tvalid && out_tready),
    .valid     (fifo_valid),
    .head      (fifo_head),
    .count     (fifo_count)
  );

  assign out_tvalid = fifo_valid;
  assign out_tdata  = {fifo_head.window_ready, fifo_head.fill_level, fifo_head.sample};
  assign out_tlast  = fifo_head.last;
  assign out_tuser  = fifo_head.status;

endmodule

@@ rtl/srbw_ram.sv @@
module srbw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/srbw_out_fifo.sv @@
module srbw_out_fifo
  import srbw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    valid,
  output result_t head,
  output logic [1:0] count
);

  result_t    entry_r [FIFO_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid = (count_r != 2'd0);
  assign head  = entry_r[rd_ptr_r];
  assign count = count_r;

endmodule

@@ rtl/srbw_chk.sv @@
module srbw_chk
  import srbw_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // A stalled word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output word changed");

  // Acknowledge, not-ready and empty answers are single words with no sample.
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DATA |-> out_tlast && out_tdata[15:0] == '0)
    else $error("status word without last or with sample bits");

  // The reported fill level never exceeds the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:16] <= 7'(DEPTH))
    else $error("fill level above depth");

  // Reset empties the output queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind sample_ring_buffer_window_read srbw_chk #(.DEPTH(DEPTH)) u_srbw_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
